@@ hw/rtl/bsa_pkg.sv @@
`default_nettype none

package bsa_pkg;

   localparam int KINDS       = 3;
   localparam int ORDER_SLOTS = 5;
   localparam int MODE_W      = 2;
   localparam int PROC_W      = 3;
   localparam int STATUS_W    = 3;
   localparam int AMT_W       = 8;

   localparam logic [MODE_W-1:0] MODE_LOAD_ROW  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_LOAD_FREE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_REQUEST   = 2'd2;
   localparam logic [MODE_W-1:0] MODE_CHECK     = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK            = 3'd0;
   localparam logic [STATUS_W-1:0] ST_GRANTED       = 3'd1;
   localparam logic [STATUS_W-1:0] ST_WAIT          = 3'd2;
   localparam logic [STATUS_W-1:0] ST_UNSAFE        = 3'd3;
   localparam logic [STATUS_W-1:0] ST_OVER_NEED     = 3'd4;
   localparam logic [STATUS_W-1:0] ST_HELD_OVER_MAX = 3'd5;

   typedef struct packed {
      logic                capture;
      logic                load_row;
      logic                load_free;
      logic                grant;
      logic                rollback;
      logic                scan_init;
      logic                scan_step;
      logic [PROC_W-1:0]   scan_idx;
      logic                publish;
      logic [STATUS_W-1:0] rsp_status;
      logic                rsp_safe;
   } cmd_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic              proc_ok;
      logic              held_over_max;
      logic              over_need;
      logic              over_free;
      logic              all_found;
   } stat_type;

endpackage

`default_nettype wire

@@ hw/rtl/bsa_datapath.sv @@
`default_nettype none

module bsa_datapath #(
   parameter int PROCESSES   = 5,
   parameter int COUNT_WIDTH = 8
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire bsa_pkg::cmd_type                 cmd,
   output bsa_pkg::stat_type                     stat,
   input  wire logic [bsa_pkg::MODE_W-1:0]       req_mode,
   input  wire logic [bsa_pkg::PROC_W-1:0]       req_process,
   input  wire logic [bsa_pkg::AMT_W-1:0]        req_value_a,
   input  wire logic [bsa_pkg::AMT_W-1:0]        req_value_b,
   input  wire logic [bsa_pkg::AMT_W-1:0]        req_value_c,
   input  wire logic [bsa_pkg::AMT_W-1:0]        req_held_a,
   input  wire logic [bsa_pkg::AMT_W-1:0]        req_held_b,
   input  wire logic [bsa_pkg::AMT_W-1:0]        req_held_c,
   output logic [bsa_pkg::STATUS_W-1:0]          rsp_status,
   output logic                                  rsp_is_safe,
   output logic [bsa_pkg::PROC_W-1:0]            rsp_order_0,
   output logic [bsa_pkg::PROC_W-1:0]            rsp_order_1,
   output logic [bsa_pkg::PROC_W-1:0]            rsp_order_2,
   output logic [bsa_pkg::PROC_W-1:0]            rsp_order_3,
   output logic [bsa_pkg::PROC_W-1:0]            rsp_order_4
);

   localparam int IDX_W   = $clog2(PROCESSES);
   localparam int FOUND_W = $clog2(PROCESSES + 1);
   localparam int WORK_W  = COUNT_WIDTH + $clog2(PROCESSES + 1);
   localparam int SLOT_W  = $clog2(bsa_pkg::ORDER_SLOTS);

   // captured word
   logic [bsa_pkg::MODE_W-1:0] mode_ff;
   logic [bsa_pkg::PROC_W-1:0] proc_ff;
   logic [COUNT_WIDTH-1:0]     val_ff      [bsa_pkg::KINDS];
   logic [COUNT_WIDTH-1:0]     held_amt_ff [bsa_pkg::KINDS];

   // allocator state
   logic [COUNT_WIDTH-1:0]     need_ff  [PROCESSES][bsa_pkg::KINDS];
   logic [COUNT_WIDTH-1:0]     alloc_ff [PROCESSES][bsa_pkg::KINDS];
   logic [COUNT_WIDTH-1:0]     free_ff  [bsa_pkg::KINDS];

   // safety scan
   logic [WORK_W-1:0]          work_ff  [bsa_pkg::KINDS];
   logic [PROCESSES-1:0]       done_ff;
   logic [FOUND_W-1:0]         found_ff;
   logic [bsa_pkg::PROC_W-1:0] seq_ff   [bsa_pkg::ORDER_SLOTS];

   // result register
   logic [bsa_pkg::STATUS_W-1:0] rsp_status_ff;
   logic                         rsp_safe_ff;
   logic [bsa_pkg::PROC_W-1:0]   rsp_order_ff [bsa_pkg::ORDER_SLOTS];

   logic [IDX_W-1:0]       row;
   logic [COUNT_WIDTH-1:0] need_row  [bsa_pkg::KINDS];
   logic [COUNT_WIDTH-1:0] alloc_row [bsa_pkg::KINDS];
   logic                   fits;
   logic                   held_over_max;
   logic                   over_need;
   logic                   over_free;

   assign row = cmd.scan_step ? cmd.scan_idx[IDX_W-1:0] : proc_ff[IDX_W-1:0];

   always_comb begin
      held_over_max = 1'b0;
      over_need     = 1'b0;
      over_free     = 1'b0;
      fits          = !done_ff[row];
      for (int r = 0; r < bsa_pkg::KINDS; r++) begin
         need_row[r]  = need_ff[row][r];
         alloc_row[r] = alloc_ff[row][r];
         if (held_amt_ff[r] > val_ff[r]) begin
            held_over_max = 1'b1;
         end
         if (val_ff[r] > need_row[r]) begin
            over_need = 1'b1;
         end
         if (val_ff[r] > free_ff[r]) begin
            over_free = 1'b1;
         end
         if (WORK_W'(need_row[r]) > work_ff[r]) begin
            fits = 1'b0;
         end
      end
   end

   assign stat.mode          = mode_ff;
   assign stat.proc_ok       = proc_ff < bsa_pkg::PROC_W'(PROCESSES);
   assign stat.held_over_max = held_over_max;
   assign stat.over_need     = over_need;
   assign stat.over_free     = over_free;
   assign stat.all_found     = found_ff == FOUND_W'(PROCESSES);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < PROCESSES; p++) begin
            for (int r = 0; r < bsa_pkg::KINDS; r++) begin
               need_ff[p][r]  <= '0;
               alloc_ff[p][r] <= '0;
            end
         end
         for (int r = 0; r < bsa_pkg::KINDS; r++) begin
            free_ff[r] <= '0;
         end
      end else begin
         for (int r = 0; r < bsa_pkg::KINDS; r++) begin
            if (cmd.load_row) begin
               alloc_ff[row][r] <= held_amt_ff[r];
               need_ff[row][r]  <= val_ff[r] - held_amt_ff[r];
            end
            if (cmd.load_free) begin
               free_ff[r] <= val_ff[r];
            end
            if (cmd.grant) begin
               free_ff[r]       <= free_ff[r] - val_ff[r];
               alloc_ff[row][r] <= alloc_row[r] + val_ff[r];
               need_ff[row][r]  <= need_row[r] - val_ff[r];
            end
            if (cmd.rollback) begin
               free_ff[r]       <= free_ff[r] + val_ff[r];
               alloc_ff[row][r] <= alloc_row[r] - val_ff[r];
               need_ff[row][r]  <= need_row[r] + val_ff[r];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff        <= req_mode;
         proc_ff        <= req_process;
         val_ff[0]      <= COUNT_WIDTH'(req_value_a);
         val_ff[1]      <= COUNT_WIDTH'(req_value_b);
         val_ff[2]      <= COUNT_WIDTH'(req_value_c);
         held_amt_ff[0] <= COUNT_WIDTH'(req_held_a);
         held_amt_ff[1] <= COUNT_WIDTH'(req_held_b);
         held_amt_ff[2] <= COUNT_WIDTH'(req_held_c);
      end
      if (cmd.scan_init) begin
         done_ff  <= '0;
         found_ff <= '0;
         for (int r = 0; r < bsa_pkg::KINDS; r++) begin
            work_ff[r] <= WORK_W'(free_ff[r]);
         end
         for (int k = 0; k < bsa_pkg::ORDER_SLOTS; k++) begin
            seq_ff[k] <= '0;
         end
      end else if (cmd.scan_step && fits) begin
         seq_ff[SLOT_W'(found_ff)] <= bsa_pkg::PROC_W'(row);
         found_ff                  <= found_ff + 1'b1;
         done_ff[row]              <= 1'b1;
         for (int r = 0; r < bsa_pkg::KINDS; r++) begin
            work_ff[r] <= work_ff[r] + WORK_W'(alloc_row[r]);
         end
      end
      if (cmd.publish) begin
         rsp_status_ff <= cmd.rsp_status;
         rsp_safe_ff   <= cmd.rsp_safe;
         for (int k = 0; k < bsa_pkg::ORDER_SLOTS; k++) begin
            rsp_order_ff[k] <= cmd.rsp_safe ? seq_ff[k] : '0;
         end
      end
   end

   assign rsp_status  = rsp_status_ff;
   assign rsp_is_safe = rsp_safe_ff;
   assign rsp_order_0 = rsp_order_ff[0];
   assign rsp_order_1 = rsp_order_ff[1];
   assign rsp_order_2 = rsp_order_ff[2];
   assign rsp_order_3 = rsp_order_ff[3];
   assign rsp_order_4 = rsp_order_ff[4];

endmodule

`default_nettype wire

@@ hw/rtl/bsa_ctrl.sv @@
`default_nettype none

module bsa_ctrl #(
   parameter int PROCESSES = 5
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   input  wire bsa_pkg::stat_type stat,
   output bsa_pkg::cmd_type       cmd
);

   localparam int IDX_W = $clog2(PROCESSES);
   localparam logic [IDX_W-1:0] LAST = IDX_W'(PROCESSES - 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECIDE,
      S_INIT,
      S_SCAN,
      S_EVAL,
      S_DONE
   } state_type;

   state_type                    state_ff, state_in;
   logic [IDX_W-1:0]             idx_ff, idx_in;
   logic [IDX_W-1:0]             pass_ff, pass_in;
   logic [bsa_pkg::STATUS_W-1:0] status_ff, status_in;
   logic                         safe_ff, safe_in;
   logic                         rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      pass_in      = pass_ff;
      status_in    = status_ff;
      safe_in      = safe_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.scan_idx   = bsa_pkg::PROC_W'(idx_ff);
      cmd.rsp_status = status_ff;
      cmd.rsp_safe   = safe_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECIDE;
            end
         end
         S_DECIDE: begin
            safe_in   = 1'b0;
            status_in = bsa_pkg::ST_OK;
            state_in  = S_DONE;
            unique case (stat.mode)
               bsa_pkg::MODE_LOAD_ROW: begin
                  if (stat.proc_ok && stat.held_over_max) begin
                     status_in = bsa_pkg::ST_HELD_OVER_MAX;
                  end else if (stat.proc_ok) begin
                     cmd.load_row = 1'b1;
                  end
               end
               bsa_pkg::MODE_LOAD_FREE: begin
                  cmd.load_free = 1'b1;
               end
               bsa_pkg::MODE_REQUEST: begin
                  if (!stat.proc_ok || stat.over_need) begin
                     status_in = bsa_pkg::ST_OVER_NEED;
                  end else if (stat.over_free) begin
                     status_in = bsa_pkg::ST_WAIT;
                  end else begin
                     cmd.grant = 1'b1;
                     state_in  = S_INIT;
                  end
               end
               bsa_pkg::MODE_CHECK: begin
                  state_in = S_INIT;
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_INIT: begin
            cmd.scan_init = 1'b1;
            idx_in        = '0;
            pass_in       = '0;
            state_in      = S_SCAN;
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (idx_ff == LAST) begin
               idx_in = '0;
               if (pass_ff == LAST) begin
                  state_in = S_EVAL;
               end else begin
                  pass_in = pass_ff + 1'b1;
               end
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_EVAL: begin
            state_in = S_DONE;
            if (stat.mode == bsa_pkg::MODE_REQUEST) begin
               if (stat.all_found) begin
                  status_in = bsa_pkg::ST_GRANTED;
                  safe_in   = 1'b1;
               end else begin
                  cmd.rollback = 1'b1;
                  status_in    = bsa_pkg::ST_UNSAFE;
                  safe_in      = 1'b0;
               end
            end else begin
               status_in = bsa_pkg::ST_OK;
               safe_in   = stat.all_found;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.publish  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         pass_ff      <= '0;
         status_ff    <= bsa_pkg::ST_OK;
         safe_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         pass_ff      <= pass_in;
         status_ff    <= status_in;
         safe_ff      <= safe_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

@@ hw/rtl/bankers_safety_allocator.sv @@
// channel   ports                                    direction
// req       req_valid/req_ready, mode, process,       in
//           value_a..c, held_a..c
// rsp       rsp_valid/rsp_ready, status, is_safe,     out
//           order_0..order_4
//
// loads and rejected requests: decided, then published from the done state
// safety check, requests within need and free: init, scan and eval, then done,
// one process compare and release per cycle in the scan loop
// a new word is taken the cycle after the result enters the output register
// a stalled result lets one more word run, which then waits in its last step
// reset clears need, allocation and available to zero
`default_nettype none

module bankers_safety_allocator #(
   parameter int PROCESSES   = 5,
   parameter int COUNT_WIDTH = 8
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [bsa_pkg::MODE_W-1:0]       req_mode,
   input  wire logic [bsa_pkg::PROC_W-1:0]       req_process,
   input  wire logic [bsa_pkg::AMT_W-1:0]        req_value_a,
   input  wire logic [bsa_pkg::AMT_W-1:0]        req_value_b,
   input  wire logic [bsa_pkg::AMT_W-1:0]        req_value_c,
   input  wire logic [bsa_pkg::AMT_W-1:0]        req_held_a,
   input  wire logic [bsa_pkg::AMT_W-1:0]        req_held_b,
   input  wire logic [bsa_pkg::AMT_W-1:0]        req_held_c,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic [bsa_pkg::STATUS_W-1:0]          rsp_status,
   output logic                                  rsp_is_safe,
   output logic [bsa_pkg::PROC_W-1:0]            rsp_order_0,
   output logic [bsa_pkg::PROC_W-1:0]            rsp_order_1,
   output logic [bsa_pkg::PROC_W-1:0]            rsp_order_2,
   output logic [bsa_pkg::PROC_W-1:0]            rsp_order_3,
   output logic [bsa_pkg::PROC_W-1:0]            rsp_order_4
);

   bsa_pkg::cmd_type  cmd;
   bsa_pkg::stat_type stat;

   bsa_ctrl #(
      .PROCESSES (PROCESSES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   bsa_datapath #(
      .PROCESSES   (PROCESSES),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_mode    (req_mode),
      .req_process (req_process),
      .req_value_a (req_value_a),
      .req_value_b (req_value_b),
      .req_value_c (req_value_c),
      .req_held_a  (req_held_a),
      .req_held_b  (req_held_b),
      .req_held_c  (req_held_c),
      .rsp_status  (rsp_status),
      .rsp_is_safe (rsp_is_safe),
      .rsp_order_0 (rsp_order_0),
      .rsp_order_1 (rsp_order_1),
      .rsp_order_2 (rsp_order_2),
      .rsp_order_3 (rsp_order_3),
      .rsp_order_4 (rsp_order_4)
   );

endmodule

`default_nettype wire

@@ hw/rtl/bsa_checker.sv @@
`default_nettype none

module bsa_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_valid,
   input wire logic                             req_ready,
   input wire logic                             rsp_valid,
   input wire logic                             rsp_ready,
   input wire logic [bsa_pkg::STATUS_W-1:0]     rsp_status,
   input wire logic                             rsp_is_safe,
   input wire logic [bsa_pkg::PROC_W-1:0]       rsp_order_0,
   input wire logic [bsa_pkg::PROC_W-1:0]       rsp_order_1,
   input wire logic [bsa_pkg::PROC_W-1:0]       rsp_order_2,
   input wire logic [bsa_pkg::PROC_W-1:0]       rsp_order_3,
   input wire logic [bsa_pkg::PROC_W-1:0]       rsp_order_4
);

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_is_safe) && $stable(rsp_order_0))
      else $error("stalled result changed");

   // one word in flight at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second word taken while busy");

   // safe only on a granted request or a plain check
   a_safe_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_safe |->
         rsp_status == bsa_pkg::ST_GRANTED || rsp_status == bsa_pkg::ST_OK)
      else $error("safe flag with a failing status");

   // no partial sequence shown
   a_order_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_safe |->
         rsp_order_0 == '0 && rsp_order_1 == '0 && rsp_order_2 == '0
         && rsp_order_3 == '0 && rsp_order_4 == '0)
      else $error("order shown without a safe sequence");

   // granted status always carries the safe flag
   a_granted_safe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == bsa_pkg::ST_GRANTED |-> rsp_is_safe)
      else $error("grant reported without safe sequence");

endmodule

bind bankers_safety_allocator bsa_checker u_checker (.*);

`default_nettype wire

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

   localparam int NPROC          = 5;
   localparam int CW             = 8;
   localparam logic [bsa_pkg::AMT_W-1:0] AMT_MASK = bsa_pkg::AMT_W'((1 << CW) - 1);
   localparam int RANDOM_ITEMS   = 1375;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int TAIL_CYCLES    = 40;
   localparam logic TYPED = 1'b1;
   localparam logic PRED  = 1'b0;
   localparam logic [bsa_pkg::ORDER_SLOTS-1:0][bsa_pkg::PROC_W-1:0] IDX_ORDER =
      {3'd4, 3'd3, 3'd2, 3'd1, 3'd0};

   typedef struct packed {
      logic [bsa_pkg::MODE_W-1:0]                    mode;
      logic [bsa_pkg::PROC_W-1:0]                    proc;
      logic [bsa_pkg::KINDS-1:0][bsa_pkg::AMT_W-1:0] value;
      logic [bsa_pkg::KINDS-1:0][bsa_pkg::AMT_W-1:0] held;
   } req_word_type;

   typedef struct packed {
      logic [bsa_pkg::STATUS_W-1:0]                           status;
      logic                                                   is_safe;
      logic [bsa_pkg::ORDER_SLOTS-1:0][bsa_pkg::PROC_W-1:0]   order;
   } rsp_word_type;

   typedef struct packed {
      req_word_type w;
      logic         given;
      rsp_word_type fixed;
   } stim_row_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic [bsa_pkg::MODE_W-1:0]   req_mode = '0;
   logic [bsa_pkg::PROC_W-1:0]   req_process = '0;
   logic [bsa_pkg::AMT_W-1:0]    req_value_a = '0;
   logic [bsa_pkg::AMT_W-1:0]    req_value_b = '0;
   logic [bsa_pkg::AMT_W-1:0]    req_value_c = '0;
   logic [bsa_pkg::AMT_W-1:0]    req_held_a = '0;
   logic [bsa_pkg::AMT_W-1:0]    req_held_b = '0;
   logic [bsa_pkg::AMT_W-1:0]    req_held_c = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic [bsa_pkg::STATUS_W-1:0] rsp_status;
   logic                         rsp_is_safe;
   logic [bsa_pkg::PROC_W-1:0]   rsp_order_0;
   logic [bsa_pkg::PROC_W-1:0]   rsp_order_1;
   logic [bsa_pkg::PROC_W-1:0]   rsp_order_2;
   logic [bsa_pkg::PROC_W-1:0]   rsp_order_3;
   logic [bsa_pkg::PROC_W-1:0]   rsp_order_4;

   logic [bsa_pkg::AMT_W-1:0] need_cnt [NPROC][bsa_pkg::KINDS];
   logic [bsa_pkg::AMT_W-1:0] held_cnt [NPROC][bsa_pkg::KINDS];
   logic [bsa_pkg::AMT_W-1:0] free_cnt [bsa_pkg::KINDS];

   rsp_word_type pending_results [$];
   stim_row_type directed_rows [$];
   rsp_word_type oldest;
   int           fails = 0;
   int           idle_cycles = 0;
   logic         rsp_hold_req = 1'b0;

   bankers_safety_allocator #(
      .PROCESSES   (NPROC),
      .COUNT_WIDTH (CW)
   ) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_mode    (req_mode),
      .req_process (req_process),
      .req_value_a (req_value_a),
      .req_value_b (req_value_b),
      .req_value_c (req_value_c),
      .req_held_a  (req_held_a),
      .req_held_b  (req_held_b),
      .req_held_c  (req_held_c),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_status  (rsp_status),
      .rsp_is_safe (rsp_is_safe),
      .rsp_order_0 (rsp_order_0),
      .rsp_order_1 (rsp_order_1),
      .rsp_order_2 (rsp_order_2),
      .rsp_order_3 (rsp_order_3),
      .rsp_order_4 (rsp_order_4)
   );

   initial begin
      forever begin
         #6 clock = ~clock;
      end
   end

   function automatic logic find_safe_order(
      output logic [bsa_pkg::ORDER_SLOTS-1:0][bsa_pkg::PROC_W-1:0] seq);
      int   work [bsa_pkg::KINDS];
      logic done [NPROC];
      int   found;
      logic fits;
      seq = '0;
      found = 0;
      for (int k = 0; k < bsa_pkg::KINDS; k++) work[k] = free_cnt[k];
      for (int p = 0; p < NPROC; p++) done[p] = 1'b0;
      for (int pass = 0; pass < NPROC; pass++) begin
         for (int p = 0; p < NPROC; p++) begin
            fits = !done[p];
            for (int k = 0; k < bsa_pkg::KINDS; k++) begin
               if (need_cnt[p][k] > work[k]) fits = 1'b0;
            end
            if (fits) begin
               if (found < bsa_pkg::ORDER_SLOTS) seq[found] = bsa_pkg::PROC_W'(p);
               found++;
               for (int k = 0; k < bsa_pkg::KINDS; k++) work[k] += held_cnt[p][k];
               done[p] = 1'b1;
            end
         end
      end
      if (found != NPROC) begin
         seq = '0;
         return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic rsp_word_type bankers_predict(input req_word_type w);
      rsp_word_type r;
      logic [bsa_pkg::KINDS-1:0][bsa_pkg::AMT_W-1:0] v;
      logic [bsa_pkg::KINDS-1:0][bsa_pkg::AMT_W-1:0] h;
      logic [bsa_pkg::ORDER_SLOTS-1:0][bsa_pkg::PROC_W-1:0] seq;
      logic bad;
      logic over_need;
      logic over_free;
      r = '0;
      r.status = bsa_pkg::ST_OK;
      for (int k = 0; k < bsa_pkg::KINDS; k++) begin
         v[k] = w.value[k] & AMT_MASK;
         h[k] = w.held[k] & AMT_MASK;
      end
      case (w.mode)
         bsa_pkg::MODE_LOAD_ROW: begin
            if (w.proc < NPROC) begin
               bad = 1'b0;
               for (int k = 0; k < bsa_pkg::KINDS; k++) begin
                  if (h[k] > v[k]) bad = 1'b1;
               end
               if (bad) begin
                  r.status = bsa_pkg::ST_HELD_OVER_MAX;
               end else begin
                  for (int k = 0; k < bsa_pkg::KINDS; k++) begin
                     held_cnt[w.proc][k] = h[k];
                     need_cnt[w.proc][k] = v[k] - h[k];
                  end
               end
            end
         end
         bsa_pkg::MODE_LOAD_FREE: begin
            for (int k = 0; k < bsa_pkg::KINDS; k++) free_cnt[k] = v[k];
         end
         bsa_pkg::MODE_REQUEST: begin
            if (w.proc >= NPROC) begin
               r.status = bsa_pkg::ST_OVER_NEED;
            end else begin
               over_need = 1'b0;
               over_free = 1'b0;
               for (int k = 0; k < bsa_pkg::KINDS; k++) begin
                  if (v[k] > need_cnt[w.proc][k]) over_need = 1'b1;
                  if (v[k] > free_cnt[k]) over_free = 1'b1;
               end
               if (over_need) begin
                  r.status = bsa_pkg::ST_OVER_NEED;
               end else if (over_free) begin
                  r.status = bsa_pkg::ST_WAIT;
               end else begin
                  for (int k = 0; k < bsa_pkg::KINDS; k++) begin
                     free_cnt[k] -= v[k];
                     held_cnt[w.proc][k] += v[k];
                     need_cnt[w.proc][k] -= v[k];
                  end
                  if (find_safe_order(seq)) begin
                     r.status = bsa_pkg::ST_GRANTED;
                     r.is_safe = 1'b1;
                     r.order = seq;
                  end else begin
                     for (int k = 0; k < bsa_pkg::KINDS; k++) begin
                        free_cnt[k] += v[k];
                        held_cnt[w.proc][k] -= v[k];
                        need_cnt[w.proc][k] += v[k];
                     end
                     r.status = bsa_pkg::ST_UNSAFE;
                  end
               end
            end
         end
         default: begin
            r.is_safe = find_safe_order(seq);
            r.order = seq;
         end
      endcase
      return r;
   endfunction

   function automatic void add_row(input logic [bsa_pkg::MODE_W-1:0] mode, input int proc,
                                   input int a, input int b, input int c,
                                   input int ha, input int hb, input int hc,
                                   input logic given,
                                   input logic [bsa_pkg::STATUS_W-1:0] st,
                                   input logic safe, input logic idx_seq);
      stim_row_type row;
      row = '0;
      row.w.mode = mode;
      row.w.proc = bsa_pkg::PROC_W'(proc);
      row.w.value[0] = bsa_pkg::AMT_W'(a);
      row.w.value[1] = bsa_pkg::AMT_W'(b);
      row.w.value[2] = bsa_pkg::AMT_W'(c);
      row.w.held[0] = bsa_pkg::AMT_W'(ha);
      row.w.held[1] = bsa_pkg::AMT_W'(hb);
      row.w.held[2] = bsa_pkg::AMT_W'(hc);
      row.given = given;
      row.fixed.status = st;
      row.fixed.is_safe = safe;
      row.fixed.order = idx_seq ? IDX_ORDER : '0;
      directed_rows.push_back(row);
   endfunction

   function automatic int pick_gap();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 80) return $urandom_range(1, 3);
      if (sel < 95) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [bsa_pkg::AMT_W-1:0] pick_amt();
      if ($urandom_range(0, 3) == 0) return bsa_pkg::AMT_W'($urandom_range(0, 255));
      return bsa_pkg::AMT_W'($urandom_range(0, 15));
   endfunction

   function automatic req_word_type random_word();
      req_word_type w;
      int sel;
      int lim;
      w = '0;
      sel = $urandom_range(0, 99);
      if ($urandom_range(0, 9) == 0) w.proc = bsa_pkg::PROC_W'($urandom_range(NPROC, 7));
      else w.proc = bsa_pkg::PROC_W'($urandom_range(0, NPROC - 1));
      for (int k = 0; k < bsa_pkg::KINDS; k++) begin
         w.value[k] = pick_amt();
         w.held[k] = bsa_pkg::AMT_W'($urandom_range(0, 255));
      end
      if (sel < 15) begin
         w.mode = bsa_pkg::MODE_LOAD_ROW;
         for (int k = 0; k < bsa_pkg::KINDS; k++) begin
            if ($urandom_range(0, 5) != 0) begin
               w.held[k] = bsa_pkg::AMT_W'($urandom_range(0, w.value[k]));
            end
         end
      end else if (sel < 25) begin
         w.mode = bsa_pkg::MODE_LOAD_FREE;
      end else if (sel < 80) begin
         w.mode = bsa_pkg::MODE_REQUEST;
         if (w.proc < NPROC) begin
            for (int k = 0; k < bsa_pkg::KINDS; k++) begin
               case ($urandom_range(0, 3))
                  0, 1: begin
                     lim = need_cnt[w.proc][k];
                     if (free_cnt[k] < lim) lim = free_cnt[k];
                     w.value[k] = bsa_pkg::AMT_W'($urandom_range(0, lim));
                  end
                  2: w.value[k] = bsa_pkg::AMT_W'($urandom_range(0, need_cnt[w.proc][k]));
                  default: w.value[k] = pick_amt();
               endcase
            end
         end
      end else begin
         w.mode = bsa_pkg::MODE_CHECK;
      end
      return w;
   endfunction

   task automatic send_word(input req_word_type w, input logic given,
                            input rsp_word_type fixed);
      rsp_word_type p;
      req_valid   <= 1'b1;
      req_mode    <= w.mode;
      req_process <= w.proc;
      req_value_a <= w.value[0];
      req_value_b <= w.value[1];
      req_value_c <= w.value[2];
      req_held_a  <= w.held[0];
      req_held_b  <= w.held[1];
      req_held_c  <= w.held[2];
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      p = bankers_predict(w);
      pending_results.push_back(given ? fixed : p);
   endtask

   task automatic idle_req(input int n);
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic check_field(input string name, input int expv, input int actv);
      if (expv != actv) begin
         $error("%s mismatch: expected %0d, actual %0d", name, expv, actv);
         fails++;
      end
   endtask

   initial begin
      req_word_type w;
      for (int p = 0; p < NPROC; p++) begin
         for (int k = 0; k < bsa_pkg::KINDS; k++) begin
            need_cnt[p][k] = '0;
            held_cnt[p][k] = '0;
         end
      end
      for (int k = 0; k < bsa_pkg::KINDS; k++) free_cnt[k] = '0;

      add_row(bsa_pkg::MODE_CHECK,     0,   0,   0,   0,   0,   0,   0,
              TYPED, bsa_pkg::ST_OK, 1'b1, 1'b1);
      add_row(bsa_pkg::MODE_REQUEST,   0,   0,   0,   0,   0,   0,   0,
              TYPED, bsa_pkg::ST_GRANTED, 1'b1, 1'b1);
      add_row(bsa_pkg::MODE_REQUEST,   0,   1,   0,   0,   0,   0,   0,
              TYPED, bsa_pkg::ST_OVER_NEED, 1'b0, 1'b0);
      add_row(bsa_pkg::MODE_REQUEST,   5,   0,   0,   0,   0,   0,   0,
              TYPED, bsa_pkg::ST_OVER_NEED, 1'b0, 1'b0);
      add_row(bsa_pkg::MODE_REQUEST,   7, 255, 255, 255, 255, 255, 255,
              TYPED, bsa_pkg::ST_OVER_NEED, 1'b0, 1'b0);
      add_row(bsa_pkg::MODE_LOAD_ROW,  7,   0,   0,   0, 255, 255, 255,
              TYPED, bsa_pkg::ST_OK, 1'b0, 1'b0);
      add_row(bsa_pkg::MODE_LOAD_ROW,  5,   1,   1,   1,   0,   0,   0,
              TYPED, bsa_pkg::ST_OK, 1'b0, 1'b0);
      add_row(bsa_pkg::MODE_LOAD_ROW,  1,  10,  10,  10,  10,  11,  10,
              TYPED, bsa_pkg::ST_HELD_OVER_MAX, 1'b0, 1'b0);
      add_row(bsa_pkg::MODE_LOAD_ROW,  0, 255, 255, 255,   0,   0,   0,
              TYPED, bsa_pkg::ST_OK, 1'b0, 1'b0);
      add_row(bsa_pkg::MODE_LOAD_ROW,  1, 255, 255, 255, 255, 255, 255,
              TYPED, bsa_pkg::ST_OK, 1'b0, 1'b0);
      add_row(bsa_pkg::MODE_REQUEST,   0,   1,   1,   1,   0,   0,   0,
              TYPED, bsa_pkg::ST_WAIT, 1'b0, 1'b0);
      add_row(bsa_pkg::MODE_LOAD_FREE, 0, 255, 255, 255,   0,   0,   0,
              TYPED, bsa_pkg::ST_OK, 1'b0, 1'b0);
      add_row(bsa_pkg::MODE_CHECK,     0,   0,   0,   0,   0,   0,   0,
              PRED, bsa_pkg::ST_OK, 1'b0, 1'b0);
      add_row(bsa_pkg::MODE_REQUEST,   0, 255, 255, 255,   0,   0,   0,
              PRED, bsa_pkg::ST_OK, 1'b0, 1'b0);
      add_row(bsa_pkg::MODE_LOAD_ROW,  2,   7,   5,   3,   0,   1,   0,
              TYPED, bsa_pkg::ST_OK, 1'b0, 1'b0);
      add_row(bsa_pkg::MODE_LOAD_ROW,  3,   3,   2,   2,   2,   0,   0,
              TYPED, bsa_pkg::ST_OK, 1'b0, 1'b0);
      add_row(bsa_pkg::MODE_LOAD_ROW,  4,   9,   0,   2,   3,   0,   2,
              TYPED, bsa_pkg::ST_OK, 1'b0, 1'b0);
      add_row(bsa_pkg::MODE_LOAD_ROW,  0,   7,   4,   3,   0,   1,   0,
              TYPED, bsa_pkg::ST_OK, 1'b0, 1'b0);
      add_row(bsa_pkg::MODE_LOAD_ROW,  1,   3,   2,   2,   2,   0,   0,
              TYPED, bsa_pkg::ST_OK, 1'b0, 1'b0);
      add_row(bsa_pkg::MODE_LOAD_FREE, 6,   3,   3,   2, 170,  85, 255,
              TYPED, bsa_pkg::ST_OK, 1'b0, 1'b0);
      add_row(bsa_pkg::MODE_CHECK,     0,   0,   0,   0,   0,   0,   0,
              PRED, bsa_pkg::ST_OK, 1'b0, 1'b0);
      add_row(bsa_pkg::MODE_REQUEST,   0,   3,   3,   2,   0,   0,   0,
              PRED, bsa_pkg::ST_OK, 1'b0, 1'b0);
      add_row(bsa_pkg::MODE_REQUEST,   1,   1,   0,   2,   0,   0,   0,
              PRED, bsa_pkg::ST_OK, 1'b0, 1'b0);
      add_row(bsa_pkg::MODE_LOAD_FREE, 0,   0,   0,   0,   0,   0,   0,
              TYPED, bsa_pkg::ST_OK, 1'b0, 1'b0);
      add_row(bsa_pkg::MODE_CHECK,     0,   0,   0,   0,   0,   0,   0,
              PRED, bsa_pkg::ST_OK, 1'b0, 1'b0);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_word(directed_rows[i].w, directed_rows[i].given, directed_rows[i].fixed);
         if ($urandom_range(0, 1) == 0) idle_req(pick_gap());
      end

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == 400) rsp_hold_req <= 1'b1;
         if (i == 800) wait_drained();
         w = random_word();
         send_word(w, PRED, '0);
         if (!(i >= 200 && i < 300) && $urandom_range(0, 9) < 6) idle_req(pick_gap());
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fails == 0 && pending_results.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      int   ready_gap;
      int   calm;
      logic held_once;
      ready_gap = 0;
      calm = 0;
      held_once = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_req && !held_once) begin
            held_once = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_ready <= 1'b1;
         end else if (ready_gap > 0) begin
            rsp_ready <= 1'b0;
            ready_gap--;
         end else begin
            rsp_ready <= 1'b1;
            if (calm > 0) begin
               calm--;
            end else if ($urandom_range(0, 199) == 0) begin
               calm = 150;
            end else if ($urandom_range(0, 3) == 0) begin
               ready_gap = pick_gap();
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("result word with nothing pending");
            fails++;
         end else begin
            oldest = pending_results.pop_front();
            check_field("status", oldest.status, rsp_status);
            check_field("is_safe", oldest.is_safe, rsp_is_safe);
            check_field("order_0", oldest.order[0], rsp_order_0);
            check_field("order_1", oldest.order[1], rsp_order_1);
            check_field("order_2", oldest.order[2], rsp_order_2);
            check_field("order_3", oldest.order[3], rsp_order_3);
            check_field("order_4", oldest.order[4], rsp_order_4);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

endmodule
